@@ src/floored_signed_divider_assert.svh @@
// ---------------------------------------------------------------------------
// floored_signed_divider_assert.svh
// assertion macros shared by the divider checks
// ---------------------------------------------------------------------------
`ifndef FLOORED_SIGNED_DIVIDER_ASSERT_SVH
`define FLOORED_SIGNED_DIVIDER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, muted in reset
`define FSD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider check failed");

// next-cycle implication, sampled on the rising edge, muted in reset
`define FSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("divider check failed");

// next-cycle implication that stays live during reset
`define FSD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("divider check failed");

`endif

@@ src/fsd_pkg.sv @@
// ---------------------------------------------------------------------------
// fsd_pkg
// shared constants and types of the floored signed divider
// ---------------------------------------------------------------------------
package fsd_pkg;

  // default operand width
  localparam int DATA_WIDTH = 32;

  // flags that travel with each operand pair down the pipeline
  typedef struct packed {
    logic div_zero;  // divisor was zero
    logic ovf;       // most negative divided by minus one
    logic neg_a;     // dividend negative
    logic differ;    // operand signs differ
  } fsd_flags_t;

endpackage

@@ src/floored_signed_divider.sv @@
// ---------------------------------------------------------------------------
// floored_signed_divider
// pipelined signed divider with floored quotient and divisor-signed remainder
// ---------------------------------------------------------------------------
// Accepts one operand pair per clock and returns one result per clock when
// not stalled. The pipeline is one operand stage, WIDTH restoring division
// stages (each a WIDTH+1-bit subtract and compare giving one quotient bit)
// and one correction stage that also holds the output register. Each stage
// has its own valid bit and ready, so a stall at the output only holds the
// stages that are full and empty stages keep filling. A zero divisor gives
// quotient 0, remainder equal to the dividend and the divide_by_zero flag;
// the most negative value divided by minus one saturates the quotient to
// the largest positive value with remainder 0 and the overflow flag.
module floored_signed_divider
  import fsd_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // dividend, divisor (from bit 0 up), zero padded to bytes
  input  logic [((2 * WIDTH + 7) / 8) * 8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // quotient, remainder (from bit 0 up), zero padded to bytes
  output logic [((2 * WIDTH + 7) / 8) * 8-1:0] m_tdata,
  // divide_by_zero, overflow (from bit 0 up)
  output logic [1:0]                           m_tuser
);

  localparam int OUT_W = ((2 * WIDTH + 7) / 8) * 8;

  logic             valid [0:WIDTH];
  logic             ready [0:WIDTH];
  logic [WIDTH-1:0] rem   [0:WIDTH];
  logic [WIDTH-1:0] qs    [0:WIDTH];
  logic [WIDTH-1:0] bm    [0:WIDTH];
  logic [WIDTH-1:0] a     [0:WIDTH];
  logic [WIDTH-1:0] b     [0:WIDTH];
  fsd_flags_t       flags [0:WIDTH];

  // operand stage
  fsd_prep #(.WIDTH(WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .dividend  (s_tdata[WIDTH-1:0]),
    .divisor   (s_tdata[2*WIDTH-1:WIDTH]),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .rem       (rem[0]),
    .qs        (qs[0]),
    .bm        (bm[0]),
    .a         (a[0]),
    .b         (b[0]),
    .flags     (flags[0])
  );

  // division stages, most significant quotient bit first
  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    fsd_step #(.WIDTH(WIDTH)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .rem_in    (rem[i]),
      .qs_in     (qs[i]),
      .bm_in     (bm[i]),
      .a_in      (a[i]),
      .b_in      (b[i]),
      .flags_in  (flags[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .rem       (rem[i+1]),
      .qs        (qs[i+1]),
      .bm        (bm[i+1]),
      .a         (a[i+1]),
      .b         (b[i+1]),
      .flags     (flags[i+1])
    );
  end

  // correction and output register
  fsd_fix #(.WIDTH(WIDTH), .OUT_W(OUT_W)) u_fix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid[WIDTH]),
    .in_ready (ready[WIDTH]),
    .rem_in   (rem[WIDTH]),
    .qs_in    (qs[WIDTH]),
    .a_in     (a[WIDTH]),
    .b_in     (b[WIDTH]),
    .flags_in (flags[WIDTH]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ src/fsd_prep.sv @@
// ---------------------------------------------------------------------------
// fsd_prep
// operand stage: magnitudes, sign flags and special case detection
// ---------------------------------------------------------------------------
module fsd_prep
  import fsd_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] qs,
  output logic [WIDTH-1:0] bm,
  output logic [WIDTH-1:0] a,
  output logic [WIDTH-1:0] b,
  output fsd_flags_t       flags
);

  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

  logic             neg_a;
  logic             neg_b;
  logic [WIDTH-1:0] am;
  logic [WIDTH-1:0] bmag;
  fsd_flags_t       flags_next;

  // magnitudes and flags
  always_comb begin
    neg_a               = dividend[WIDTH-1];
    neg_b               = divisor[WIDTH-1];
    am                  = neg_a ? (~dividend + 1'b1) : dividend;
    bmag                = neg_b ? (~divisor + 1'b1) : divisor;
    flags_next.div_zero = (divisor == '0);
    flags_next.ovf      = (dividend == MOST_NEG) && (divisor == '1);
    flags_next.neg_a    = neg_a;
    flags_next.differ   = neg_a ^ neg_b;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      rem   <= '0;
      qs    <= am;
      bm    <= bmag;
      a     <= dividend;
      b     <= divisor;
      flags <= flags_next;
    end
  end

endmodule

@@ src/fsd_step.sv @@
// ---------------------------------------------------------------------------
// fsd_step
// one restoring division stage: one quotient bit per stage
// ---------------------------------------------------------------------------
module fsd_step
  import fsd_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] qs_in,
  input  logic [WIDTH-1:0] bm_in,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  fsd_flags_t       flags_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] qs,
  output logic [WIDTH-1:0] bm,
  output logic [WIDTH-1:0] a,
  output logic [WIDTH-1:0] b,
  output fsd_flags_t       flags
);

  logic [WIDTH-1:0] shifted;
  logic [WIDTH:0]   trial;
  logic             fits;
  logic [WIDTH-1:0] rem_next;

  // partial remainder stays below the divisor, so its top bit is free
  always_comb begin
    shifted  = {rem_in[WIDTH-2:0], qs_in[WIDTH-1]};
    trial    = {1'b0, shifted} - {1'b0, bm_in};
    fits     = !trial[WIDTH];
    rem_next = fits ? trial[WIDTH-1:0] : shifted;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      rem   <= rem_next;
      qs    <= {qs_in[WIDTH-2:0], fits};
      bm    <= bm_in;
      a     <= a_in;
      b     <= b_in;
      flags <= flags_in;
    end
  end

endmodule

@@ src/fsd_fix.sv @@
// ---------------------------------------------------------------------------
// fsd_fix
// sign restore, floor correction, special cases and output register
// ---------------------------------------------------------------------------
module fsd_fix
  import fsd_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH,
  parameter int OUT_W = ((2 * WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] qs_in,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  fsd_flags_t       flags_in,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic [1:0]       m_tuser
);

  localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

  logic             floor_fix;
  logic [WIDTH-1:0] q_res;
  logic [WIDTH-1:0] r_res;
  logic [OUT_W-1:0] data_next;

  // floored result; when flooring, -q-1 is ~q and the remainder is one add
  always_comb begin
    floor_fix = flags_in.differ && (rem_in != '0);
    if (floor_fix) begin
      q_res = ~qs_in;
      r_res = flags_in.neg_a ? (b_in - rem_in) : (b_in + rem_in);
    end else begin
      q_res = flags_in.differ ? (~qs_in + 1'b1) : qs_in;
      r_res = flags_in.neg_a ? (~rem_in + 1'b1) : rem_in;
    end
    if (flags_in.div_zero) begin
      q_res = '0;
      r_res = a_in;
    end else if (flags_in.ovf) begin
      q_res = MOST_POS;
      r_res = '0;
    end
    data_next                = '0;
    data_next[WIDTH-1:0]     = q_res;
    data_next[2*WIDTH-1:WIDTH] = r_res;
  end

  assign in_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
    if (in_ready) begin
      m_tdata <= data_next;
      m_tuser <= {flags_in.ovf, flags_in.div_zero};
    end
  end

endmodule

@@ src/fsd_check.sv @@
// ---------------------------------------------------------------------------
// fsd_check
// port-level checks of the floored signed divider, bound to the top level
// ---------------------------------------------------------------------------
`include "floored_signed_divider_assert.svh"

module fsd_check
  import fsd_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((2 * WIDTH + 7) / 8) * 8-1:0] m_tdata,
  input logic [1:0]                           m_tuser
);

  localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rmd;

  // result fields of the output beat
  assign quo = m_tdata[WIDTH-1:0];
  assign rmd = m_tdata[2*WIDTH-1:WIDTH];

  // a stalled result beat keeps its payload
  `FSD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

  // the two flags never come together
  `FSD_ASSERT_NOW(a_flags, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))

  // zero divisor gives a zero quotient
  `FSD_ASSERT_NOW(a_dz_q, clk, rst, m_tvalid && m_tuser[0], quo == '0)

  // saturation gives the largest quotient and no remainder
  `FSD_ASSERT_NOW(a_ovf, clk, rst, m_tvalid && m_tuser[1], (quo == MOST_POS) && (rmd == '0))

  // nothing on the output in the cycle after a reset cycle
  `FSD_ASSERT_ALWAYS(a_rst, clk, rst, !m_tvalid)

endmodule

bind floored_signed_divider fsd_check #(.WIDTH(WIDTH)) u_fsd_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
